[hdl/mgw_pkg.sv]
package mgw_pkg;

    localparam int NUM_BINS   = 128;
    localparam int BIN_W      = $clog2(NUM_BINS);
    localparam int POS_FRAC   = 20;
    localparam int X2_SH      = 2 * POS_FRAC - 16;
    localparam int BIN_SH     = POS_FRAC + 16;

    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;

    localparam int DIV_NUM_W  = 72;
    localparam int DIV_DEN_W  = 46;
    localparam int DIV_Q_W    = 41;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

    localparam int EXP_ITERS  = 21;

    typedef enum logic [1:0] {
        CAP_RATIO,
        CAP_T1,
        CAP_TERM
    } t_cap;

    typedef struct packed {
        logic start;
        t_cap cap;
    } t_div_ctl;

    typedef enum logic [2:0] {
        REG_PEAK_OFFSET    = 3'd0,
        REG_PEAK_SPREAD    = 3'd1,
        REG_START_POSITION = 3'd2,
        REG_KINETIC_FACTOR = 3'd3,
        REG_INV_BIN_WIDTH  = 3'd4
    } t_reg;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQ_W,
        ST_PROP,
        ST_PROP_W,
        ST_SH_D,
        ST_SH_Y_GO,
        ST_SH_Y_WT,
        ST_SH_B,
        ST_SH_B_GO,
        ST_SH_B_WT,
        ST_SH_E,
        ST_EXP,
        ST_EXP_RND,
        ST_ACC_FO,
        ST_ACC_FN,
        ST_ACC_PO,
        ST_ACC_LO,
        ST_ACC_PN,
        ST_ACC_LN,
        ST_ACC_U,
        ST_ACC_CMP,
        ST_T1_GO,
        ST_T1_WT,
        ST_BT,
        ST_KD,
        ST_KM,
        ST_K_GO,
        ST_K_WT,
        ST_X2,
        ST_X4,
        ST_BIN,
        ST_OUT
    } t_state;

    function automatic logic [30:0] exp_tab(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd1073725440;
            5'd1:    v = 31'd1073709056;
            5'd2:    v = 31'd1073676290;
            5'd3:    v = 31'd1073610760;
            5'd4:    v = 31'd1073479712;
            5'd5:    v = 31'd1073217664;
            5'd6:    v = 31'd1072693760;
            5'd7:    v = 31'd1071646719;
            5'd8:    v = 31'd1069555701;
            5'd9:    v = 31'd1065385899;
            5'd10:   v = 31'd1057095000;
            5'd11:   v = 31'd1040706261;
            5'd12:   v = 31'd1008687096;
            5'd13:   v = 31'd947573834;
            5'd14:   v = 31'd836230973;
            5'd15:   v = 31'd651257337;
            5'd16:   v = 31'd395007542;
            5'd17:   v = 31'd145315154;
            5'd18:   v = 31'd19666268;
            5'd19:   v = 31'd360200;
            5'd20:   v = 31'd121;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/mgw_div.sv]
module mgw_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mgw_pkg::t_div_ctl              i_ctl,
    input  logic [mgw_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [mgw_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [mgw_pkg::DIV_Q_W-1:0]    o_quot
);

    localparam int NW = mgw_pkg::DIV_NUM_W;
    localparam int DW = mgw_pkg::DIV_DEN_W;
    localparam int QW = mgw_pkg::DIV_Q_W;
    localparam int CW = mgw_pkg::DIV_CNT_W;

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [NW-1:0]       r_num;
    logic [DW-1:0]       r_den;
    logic [DW-1:0]       r_rem;
    logic [QW-1:0]       r_q;
    logic                r_sticky;
    mgw_pkg::t_cap       r_cap;

    logic [DW:0]         w_trial;
    logic                w_ge;
    logic [DW-1:0]       n_rem;
    logic                w_sat;
    logic [QW-1:0]       w_cap_val;

    always_comb begin
        w_trial = {r_rem, r_num[NW-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        n_rem   = w_ge ? DW'(w_trial - {1'b0, r_den}) : w_trial[DW-1:0];
    end

    always_comb begin
        case (r_cap)
            mgw_pkg::CAP_RATIO: begin
                w_sat     = r_sticky | (|r_q[QW-1:26]);
                w_cap_val = QW'(1) << 26;
            end
            mgw_pkg::CAP_T1: begin
                w_sat     = r_sticky | (|r_q[QW-1:17]);
                w_cap_val = QW'(1) << 17;
            end
            default: begin
                w_sat     = r_sticky | r_q[QW-1];
                w_cap_val = QW'(1) << (QW - 1);
            end
        endcase
    end

    assign o_quot = w_sat ? w_cap_val : r_q;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num    <= i_num;
            r_den    <= i_den;
            r_rem    <= '0;
            r_q      <= '0;
            r_sticky <= 1'b0;
            r_cap    <= i_ctl.cap;
        end else if (r_busy) begin
            r_num    <= {r_num[NW-2:0], 1'b0};
            r_rem    <= n_rem;
            r_q      <= {r_q[QW-2:0], w_ge};
            r_sticky <= r_sticky | r_q[QW-1];
        end
    end

endmodule

[hdl/metropolis_double_gaussian_walker.sv]
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_action, i_rand_move, i_rand_accept
// output    out        o_out_valid / i_out_ready   o_position, o_move_accepted,
//                                                  o_local_energy, o_histogram_bin,
//                                                  o_bin_in_range
// config    in         psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// The time a restart beat or a Metropolis step beat takes is set by the restoring divider,
// used four times for a restart and six times for a step, and by the exponentials on
// the shared multiplier.
// Reset is synchronous and loads the register defaults and a walker position of zero.
// The block takes one input beat at a time; a finished result waits in the output
// register, and a following result stalls only while that register is still full.
module metropolis_double_gaussian_walker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [23:0]        i_rand_move,
    input  logic [23:0]        i_rand_accept,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_position,
    output logic               o_move_accepted,
    output logic signed [23:0] o_local_energy,
    output logic [6:0]         o_histogram_bin,
    output logic               o_bin_in_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int MW  = mgw_pkg::MUL_W;
    localparam int PW  = mgw_pkg::PROD_W;
    localparam int NW  = mgw_pkg::DIV_NUM_W;
    localparam int DW  = mgw_pkg::DIV_DEN_W;
    localparam int QW  = mgw_pkg::DIV_Q_W;
    localparam int BW  = mgw_pkg::BIN_W;
    localparam int X2S = mgw_pkg::X2_SH;
    localparam int BS  = mgw_pkg::BIN_SH;
    localparam int FLW = 48 - BS;

    mgw_pkg::t_state r_state, n_state, r_exp_ret;

    logic [22:0]        r_peak_offset;
    logic [22:0]        r_peak_spread;
    logic signed [23:0] r_start_position;
    logic [22:0]        r_kinetic_factor;
    logic [23:0]        r_inv_bin_width;

    logic               r_action;
    logic [23:0]        r_rand_move;
    logic [23:0]        r_rand_accept;
    logic signed [23:0] r_x;
    logic signed [23:0] r_xn;
    logic               r_sel;
    logic               r_acc;
    logic [DW-1:0]      r_s2;
    logic [26:0]        r_yo, r_yn, r_bo, r_bn;
    logic [30:0]        r_eo, r_en, r_fo, r_fn;
    logic [32:0]        r_lo, r_ln;
    logic [17:0]        r_t1;
    logic [28:0]        r_dmag;
    logic               r_neg;
    logic [40:0]        r_mag;
    logic [22:0]        r_x2q;
    logic [28:0]        r_x4q;
    logic [26:0]        r_exp_y;
    logic [30:0]        r_exp_r;
    logic [4:0]         r_exp_i;
    logic [PW-1:0]      r_prod;

    logic               r_out_valid;
    logic signed [23:0] r_o_position;
    logic               r_o_move_accepted;
    logic signed [23:0] r_o_local_energy;
    logic [6:0]         r_o_histogram_bin;
    logic               r_o_bin_in_range;

    logic [MW-1:0]      w_mul_a, w_mul_b;
    mgw_pkg::t_div_ctl  w_div_ctl;
    logic [NW-1:0]      w_div_num;
    logic [DW-1:0]      w_div_den;
    logic               w_div_done;
    logic [QW-1:0]      w_div_quot;

    logic               w_in_acc;
    logic               w_out_load;
    logic               w_cfg_wr;
    logic [22:0]        w_s_eff;
    logic [24:0]        w_range;
    logic signed [27:0] w_xn_full;
    logic signed [23:0] w_xn_sat;
    logic signed [23:0] w_x_sel;
    logic [23:0]        w_ax_sel;
    logic [23:0]        w_ax;
    logic [23:0]        w_d;
    logic [26:0]        w_c;
    logic [26:0]        w_y_cur, w_b_cur;
    logic [30:0]        w_e_cur;
    logic [31:0]        w_to, w_tn, w_te;
    logic [28:0]        w_dsum;
    logic               w_exp_load;
    logic [26:0]        w_exp_y_in;
    logic               w_exp_bit;
    logic [25:0]        w_five;
    logic signed [42:0] w_kin, w_pot, w_sum;
    logic signed [23:0] w_energy;
    logic [47:0]        w_p;
    logic [FLW:0]       w_fl;
    logic signed [14:0] w_bin;
    logic               w_inr;
    logic [BW-1:0]      w_bin_clamp;

    assign pready          = 1'b1;
    assign o_in_ready      = (r_state == mgw_pkg::ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_position      = r_o_position;
    assign o_move_accepted = r_o_move_accepted;
    assign o_local_energy  = r_o_local_energy;
    assign o_histogram_bin = r_o_histogram_bin;
    assign o_bin_in_range  = r_o_bin_in_range;

    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_out_load = (r_state == mgw_pkg::ST_OUT) && (!r_out_valid || i_out_ready);
    assign w_cfg_wr   = psel & penable & pwrite;

    always_comb begin
        case (mgw_pkg::t_reg'(paddr[4:2]))
            mgw_pkg::REG_PEAK_OFFSET:    prdata = 32'(r_peak_offset);
            mgw_pkg::REG_PEAK_SPREAD:    prdata = 32'(r_peak_spread);
            mgw_pkg::REG_START_POSITION: prdata = 32'(r_start_position);
            mgw_pkg::REG_KINETIC_FACTOR: prdata = 32'(r_kinetic_factor);
            mgw_pkg::REG_INV_BIN_WIDTH:  prdata = 32'(r_inv_bin_width);
            default:                     prdata = 32'd0;
        endcase
    end

    always_comb begin
        w_s_eff   = (r_peak_spread == '0) ? 23'd1 : r_peak_spread;
        w_range   = 25'(r_peak_offset) + {1'b0, w_s_eff, 1'b0};
        w_xn_full = 28'(r_x) + $signed({2'b00, r_prod[49:24]}) - $signed({3'b000, w_range});
        if (w_xn_full > 28'sd8388607) begin
            w_xn_sat = 24'sh7FFFFF;
        end else if (w_xn_full < -28'sd8388608) begin
            w_xn_sat = -24'sh800000;
        end else begin
            w_xn_sat = w_xn_full[23:0];
        end
        w_x_sel  = r_sel ? r_xn : r_x;
        w_ax_sel = w_x_sel[23] ? 24'(-w_x_sel) : 24'(w_x_sel);
        w_ax     = r_x[23] ? 24'(-r_x) : 24'(r_x);
        w_d      = (w_ax_sel > 24'(r_peak_offset)) ? w_ax_sel - 24'(r_peak_offset)
                                                   : 24'(r_peak_offset) - w_ax_sel;
        w_c      = (r_yo < r_yn) ? r_yo : r_yn;
        w_y_cur  = r_acc ? r_yn : r_yo;
        w_b_cur  = r_acc ? r_bn : r_bo;
        w_e_cur  = r_acc ? r_en : r_eo;
        w_to     = 32'h4000_0000 + 32'(r_eo);
        w_tn     = 32'h4000_0000 + 32'(r_en);
        w_te     = 32'h4000_0000 + 32'(w_e_cur);
        w_dsum   = 29'(w_y_cur) + 29'(r_prod[43:16]);
        w_exp_bit = r_exp_y[r_exp_i];
    end

    always_comb begin
        w_five   = {1'b0, r_x2q, 2'b00} + 26'(r_x2q);
        w_kin    = r_neg ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
        w_pot    = $signed({14'd0, r_x4q}) - $signed({18'd0, w_five[25:1]});
        w_sum    = w_kin + w_pot;
        if (w_sum > 43'sd8388607) begin
            w_energy = 24'sh7FFFFF;
        end else if (w_sum < -43'sd8388608) begin
            w_energy = -24'sh800000;
        end else begin
            w_energy = w_sum[23:0];
        end
        w_p = r_prod[47:0];
        if (r_x[23]) begin
            w_fl  = (FLW + 1)'((49'(w_p) + ((49'(1) << BS) - 49'(1))) >> BS);
            w_bin = 15'(mgw_pkg::NUM_BINS / 2) - 15'(w_fl);
        end else begin
            w_fl  = (FLW + 1)'(w_p >> BS);
            w_bin = 15'(mgw_pkg::NUM_BINS / 2) + 15'(w_fl);
        end
        w_inr = (w_bin >= 15'sd0) && (w_bin < 15'(mgw_pkg::NUM_BINS));
        if (w_bin < 15'sd0) begin
            w_bin_clamp = '0;
        end else if (w_bin >= 15'(mgw_pkg::NUM_BINS)) begin
            w_bin_clamp = BW'(mgw_pkg::NUM_BINS - 1);
        end else begin
            w_bin_clamp = w_bin[BW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mgw_pkg::ST_IDLE:    if (w_in_acc) n_state = mgw_pkg::ST_SQ;
            mgw_pkg::ST_SQ:      n_state = mgw_pkg::ST_SQ_W;
            mgw_pkg::ST_SQ_W:    n_state = r_action ? mgw_pkg::ST_SH_D : mgw_pkg::ST_PROP;
            mgw_pkg::ST_PROP:    n_state = mgw_pkg::ST_PROP_W;
            mgw_pkg::ST_PROP_W:  n_state = mgw_pkg::ST_SH_D;
            mgw_pkg::ST_SH_D:    n_state = mgw_pkg::ST_SH_Y_GO;
            mgw_pkg::ST_SH_Y_GO: n_state = mgw_pkg::ST_SH_Y_WT;
            mgw_pkg::ST_SH_Y_WT: if (w_div_done) n_state = mgw_pkg::ST_SH_B;
            mgw_pkg::ST_SH_B:    n_state = mgw_pkg::ST_SH_B_GO;
            mgw_pkg::ST_SH_B_GO: n_state = mgw_pkg::ST_SH_B_WT;
            mgw_pkg::ST_SH_B_WT: if (w_div_done) n_state = mgw_pkg::ST_EXP;
            mgw_pkg::ST_SH_E: begin
                if (r_action) begin
                    n_state = mgw_pkg::ST_T1_GO;
                end else if (!r_sel) begin
                    n_state = mgw_pkg::ST_SH_D;
                end else begin
                    n_state = mgw_pkg::ST_ACC_FO;
                end
            end
            mgw_pkg::ST_EXP: begin
                if (r_exp_i == 5'(mgw_pkg::EXP_ITERS)) begin
                    n_state = r_exp_ret;
                end else if (w_exp_bit) begin
                    n_state = mgw_pkg::ST_EXP_RND;
                end
            end
            mgw_pkg::ST_EXP_RND: n_state = mgw_pkg::ST_EXP;
            mgw_pkg::ST_ACC_FO:  n_state = mgw_pkg::ST_EXP;
            mgw_pkg::ST_ACC_FN:  n_state = mgw_pkg::ST_EXP;
            mgw_pkg::ST_ACC_PO:  n_state = mgw_pkg::ST_ACC_LO;
            mgw_pkg::ST_ACC_LO:  n_state = mgw_pkg::ST_ACC_PN;
            mgw_pkg::ST_ACC_PN:  n_state = mgw_pkg::ST_ACC_LN;
            mgw_pkg::ST_ACC_LN:  n_state = mgw_pkg::ST_ACC_U;
            mgw_pkg::ST_ACC_U:   n_state = mgw_pkg::ST_ACC_CMP;
            mgw_pkg::ST_ACC_CMP: n_state = mgw_pkg::ST_T1_GO;
            mgw_pkg::ST_T1_GO:   n_state = mgw_pkg::ST_T1_WT;
            mgw_pkg::ST_T1_WT:   if (w_div_done) n_state = mgw_pkg::ST_BT;
            mgw_pkg::ST_BT:      n_state = mgw_pkg::ST_KD;
            mgw_pkg::ST_KD:      n_state = mgw_pkg::ST_KM;
            mgw_pkg::ST_KM:      n_state = mgw_pkg::ST_K_GO;
            mgw_pkg::ST_K_GO:    n_state = mgw_pkg::ST_K_WT;
            mgw_pkg::ST_K_WT:    if (w_div_done) n_state = mgw_pkg::ST_X2;
            mgw_pkg::ST_X2:      n_state = mgw_pkg::ST_X4;
            mgw_pkg::ST_X4:      n_state = mgw_pkg::ST_BIN;
            mgw_pkg::ST_BIN:     n_state = mgw_pkg::ST_OUT;
            mgw_pkg::ST_OUT:     if (w_out_load) n_state = mgw_pkg::ST_IDLE;
            default:             n_state = mgw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_mul_a        = '0;
        w_mul_b        = '0;
        w_div_ctl      = '{start: 1'b0, cap: mgw_pkg::CAP_RATIO};
        w_div_num      = '0;
        w_div_den      = r_s2;
        w_exp_load     = 1'b0;
        w_exp_y_in     = w_div_quot[26:0];
        case (r_state)
            mgw_pkg::ST_SQ: begin
                w_mul_a = MW'(w_s_eff);
                w_mul_b = MW'(w_s_eff);
            end
            mgw_pkg::ST_PROP: begin
                w_mul_a = MW'(w_range);
                w_mul_b = MW'({r_rand_move, 1'b0});
            end
            mgw_pkg::ST_SH_D: begin
                w_mul_a = MW'(w_d);
                w_mul_b = MW'(w_d);
            end
            mgw_pkg::ST_SH_Y_GO: begin
                w_div_ctl = '{start: 1'b1, cap: mgw_pkg::CAP_RATIO};
                w_div_num = NW'(r_prod[46:0]) << 16;
            end
            mgw_pkg::ST_SH_B: begin
                w_mul_a = MW'(w_ax_sel);
                w_mul_b = MW'(r_peak_offset);
            end
            mgw_pkg::ST_SH_B_GO: begin
                w_div_ctl = '{start: 1'b1, cap: mgw_pkg::CAP_RATIO};
                w_div_num = NW'(r_prod[46:0]) << 17;
            end
            mgw_pkg::ST_SH_B_WT: begin
                w_exp_load = w_div_done;
            end
            mgw_pkg::ST_EXP: begin
                w_mul_a = MW'(r_exp_r);
                w_mul_b = MW'(mgw_pkg::exp_tab(r_exp_i));
            end
            mgw_pkg::ST_ACC_FO: begin
                w_exp_load = 1'b1;
                w_exp_y_in = r_yo - w_c;
            end
            mgw_pkg::ST_ACC_FN: begin
                w_exp_load = 1'b1;
                w_exp_y_in = r_yn - w_c;
            end
            mgw_pkg::ST_ACC_PO: begin
                w_mul_a = MW'(w_to);
                w_mul_b = MW'(w_to);
            end
            mgw_pkg::ST_ACC_LO: begin
                w_mul_a = MW'(r_prod[62:30]);
                w_mul_b = MW'(r_fo);
            end
            mgw_pkg::ST_ACC_PN: begin
                w_mul_a = MW'(w_tn);
                w_mul_b = MW'(w_tn);
            end
            mgw_pkg::ST_ACC_LN: begin
                w_mul_a = MW'(r_prod[62:30]);
                w_mul_b = MW'(r_fn);
            end
            mgw_pkg::ST_ACC_U: begin
                w_mul_a = MW'(r_rand_accept);
                w_mul_b = MW'(r_lo);
            end
            mgw_pkg::ST_T1_GO: begin
                w_div_ctl = '{start: 1'b1, cap: mgw_pkg::CAP_T1};
                w_div_num = NW'({w_e_cur, 1'b0}) << 16;
                w_div_den = DW'(w_te);
            end
            mgw_pkg::ST_BT: begin
                w_mul_a = MW'(w_b_cur);
                w_mul_b = MW'(r_t1);
            end
            mgw_pkg::ST_KM: begin
                w_mul_a = MW'(r_dmag);
                w_mul_b = MW'(r_kinetic_factor);
            end
            mgw_pkg::ST_K_GO: begin
                w_div_ctl = '{start: 1'b1, cap: mgw_pkg::CAP_TERM};
                w_div_num = NW'(r_prod[51:0]) << mgw_pkg::POS_FRAC;
            end
            mgw_pkg::ST_X2: begin
                w_mul_a = MW'(w_ax);
                w_mul_b = MW'(w_ax);
            end
            mgw_pkg::ST_X4: begin
                w_mul_a = MW'(r_prod[X2S+22:X2S]);
                w_mul_b = MW'(r_prod[X2S+22:X2S]);
            end
            mgw_pkg::ST_BIN, mgw_pkg::ST_OUT: begin
                w_mul_a = MW'(w_ax);
                w_mul_b = MW'(r_inv_bin_width);
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    mgw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= mgw_pkg::ST_IDLE;
            r_out_valid      <= 1'b0;
            r_x              <= '0;
            r_sel            <= 1'b0;
            r_acc            <= 1'b0;
            r_peak_offset    <= 23'd838861;
            r_peak_spread    <= 23'd629146;
            r_start_position <= '0;
            r_kinetic_factor <= 23'd524288;
            r_inv_bin_width  <= 24'd1310720;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                case (mgw_pkg::t_reg'(paddr[4:2]))
                    mgw_pkg::REG_PEAK_OFFSET:    r_peak_offset    <= pwdata[22:0];
                    mgw_pkg::REG_PEAK_SPREAD:    r_peak_spread    <= pwdata[22:0];
                    mgw_pkg::REG_START_POSITION: r_start_position <= pwdata[23:0];
                    mgw_pkg::REG_KINETIC_FACTOR: r_kinetic_factor <= pwdata[22:0];
                    mgw_pkg::REG_INV_BIN_WIDTH:  r_inv_bin_width  <= pwdata[23:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                mgw_pkg::ST_SQ_W: begin
                    r_sel <= 1'b0;
                    r_acc <= 1'b0;
                    if (r_action) begin
                        r_x <= r_start_position;
                    end
                end
                mgw_pkg::ST_SH_E: begin
                    if (!r_action) begin
                        r_sel <= 1'b1;
                    end
                end
                mgw_pkg::ST_ACC_CMP: begin
                    if (PW'({r_ln, 24'd0}) >= r_prod) begin
                        r_acc <= 1'b1;
                        r_x   <= r_xn;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_in_acc) begin
            r_action      <= i_action;
            r_rand_move   <= i_rand_move;
            r_rand_accept <= i_rand_accept;
        end
        if (w_exp_load) begin
            r_exp_y <= w_exp_y_in;
            if (|w_exp_y_in[26:21]) begin
                r_exp_r <= '0;
                r_exp_i <= 5'(mgw_pkg::EXP_ITERS);
            end else begin
                r_exp_r <= 31'h4000_0000;
                r_exp_i <= '0;
            end
        end
        case (r_state)
            mgw_pkg::ST_SQ_W:    r_s2 <= r_prod[DW-1:0];
            mgw_pkg::ST_PROP_W:  r_xn <= w_xn_sat;
            mgw_pkg::ST_SH_Y_WT: begin
                if (w_div_done) begin
                    if (r_sel) begin
                        r_yn <= w_div_quot[26:0];
                    end else begin
                        r_yo <= w_div_quot[26:0];
                    end
                end
            end
            mgw_pkg::ST_SH_B_WT: begin
                if (w_div_done) begin
                    r_exp_ret <= mgw_pkg::ST_SH_E;
                    if (r_sel) begin
                        r_bn <= w_div_quot[26:0];
                    end else begin
                        r_bo <= w_div_quot[26:0];
                    end
                end
            end
            mgw_pkg::ST_SH_E: begin
                if (r_sel) begin
                    r_en <= r_exp_r;
                end else begin
                    r_eo <= r_exp_r;
                end
            end
            mgw_pkg::ST_EXP: begin
                if (r_exp_i != 5'(mgw_pkg::EXP_ITERS) && !w_exp_bit) begin
                    r_exp_i <= r_exp_i + 1'b1;
                end
            end
            mgw_pkg::ST_EXP_RND: begin
                r_exp_r <= 31'((r_prod + (PW'(1) << 29)) >> 30);
                r_exp_i <= r_exp_i + 1'b1;
            end
            mgw_pkg::ST_ACC_FO:  r_exp_ret <= mgw_pkg::ST_ACC_FN;
            mgw_pkg::ST_ACC_FN: begin
                r_fo      <= r_exp_r;
                r_exp_ret <= mgw_pkg::ST_ACC_PO;
            end
            mgw_pkg::ST_ACC_PO:  r_fn <= r_exp_r;
            mgw_pkg::ST_ACC_PN:  r_lo <= r_prod[62:30];
            mgw_pkg::ST_ACC_U:   r_ln <= r_prod[62:30];
            mgw_pkg::ST_T1_WT: begin
                if (w_div_done) begin
                    r_t1 <= w_div_quot[17:0];
                end
            end
            mgw_pkg::ST_KD: begin
                r_neg  <= w_dsum >= 29'd65536;
                r_dmag <= (w_dsum >= 29'd65536) ? w_dsum - 29'd65536 : 29'd65536 - w_dsum;
            end
            mgw_pkg::ST_K_WT: begin
                if (w_div_done) begin
                    r_mag <= w_div_quot;
                end
            end
            mgw_pkg::ST_X4:  r_x2q <= r_prod[X2S+22:X2S];
            mgw_pkg::ST_BIN: r_x4q <= r_prod[44:16];
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_o_position      <= r_x;
            r_o_move_accepted <= r_acc;
            r_o_local_energy  <= w_energy;
            r_o_histogram_bin <= 7'(w_bin_clamp);
            r_o_bin_in_range  <= w_inr;
        end
    end

endmodule

[verif/tb_top.sv]
module tb_top;

    typedef longint unsigned u64;

    typedef struct {
        logic               moved;
        logic signed [23:0] pos;
        logic signed [23:0] energy;
        logic [6:0]         bin;
        logic               in_range;
    } t_walk_result;

    typedef struct {
        logic        restart;
        logic [23:0] rand_move;
        logic [23:0] rand_accept;
        logic        typed;
    } t_stim_row;

    localparam u64 ONE_Q30    = 64'd1 << 30;
    localparam u64 RATIO_CAP  = 64'd1 << 26;
    localparam u64 TERM_CAP   = 64'd1 << 40;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_PHASES   = 6;
    localparam int RAND_ITEMS = 160;

    localparam u64 EXP_TAB [21] = '{
        1073725440, 1073709056, 1073676290, 1073610760,
        1073479712, 1073217664, 1072693760, 1071646719,
        1069555701, 1065385899, 1057095000, 1040706261,
        1008687096, 947573834, 836230973, 651257337,
        395007542, 145315154, 19666268, 360200, 121
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_action;
    logic [23:0]        i_rand_move;
    logic [23:0]        i_rand_accept;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [23:0] o_position;
    logic               o_move_accepted;
    logic signed [23:0] o_local_energy;
    logic [6:0]         o_histogram_bin;
    logic               o_bin_in_range;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    metropolis_double_gaussian_walker i_dut (.*);

    u64     peak_offset_q, peak_spread_q, kinetic_q, bin_density_q;
    longint start_pos_q, walker_pos;

    t_walk_result expected_beats[$];
    int errors, items_sent, beats_seen, moves_taken, restarts, off_histogram;
    int idle_cycles;
    logic no_stall_stretch;

    initial i_clk = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic u64 div_sat(u64 num, u64 den, int sh, u64 cap);
        u64 q, r;
        q = num / den;
        r = num % den;
        if (q >= cap) return cap;
        for (int i = 0; i < sh; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
            if (q >= cap) return cap;
        end
        return q;
    endfunction

    function automatic u64 exp_neg(u64 y);
        u64 r;
        r = ONE_Q30;
        if (y >= (64'd32 << 16)) return 0;
        for (int i = 0; i < 21; i++)
            if (y[i]) r = (r * EXP_TAB[i] + (64'd1 << 29)) >> 30;
        return r;
    endfunction

    function automatic u64 spread_sq();
        u64 s;
        s = (peak_spread_q != 0) ? peak_spread_q : 64'd1;
        return s * s;
    endfunction

    function automatic u64 magnitude(longint x);
        return (x < 0) ? u64'(-x) : u64'(x);
    endfunction

    function automatic void gauss_shape(input longint x, output u64 y, output u64 b,
                                        output u64 e);
        u64 ax, d;
        ax = magnitude(x);
        d = (ax > peak_offset_q) ? ax - peak_offset_q : peak_offset_q - ax;
        y = div_sat(d * d, spread_sq(), 16, RATIO_CAP);
        b = div_sat(64'd2 * ax * peak_offset_q, spread_sq(), 16, RATIO_CAP);
        e = exp_neg(b);
    endfunction

    function automatic u64 density_factor(u64 e);
        u64 t;
        t = ONE_Q30 + e;
        return (t * t) >> 30;
    endfunction

    function automatic longint energy_at(longint x);
        u64 y, b, e, t1, dsum, dmag, mag, ax, x2q, x4q;
        longint kin, pot, sum;
        logic neg;
        gauss_shape(x, y, b, e);
        t1 = div_sat(64'd2 * e, ONE_Q30 + e, 16, 64'd1 << 17);
        dsum = y + ((b * t1) >> 16);
        neg = dsum >= 64'd65536;
        dmag = neg ? dsum - 64'd65536 : 64'd65536 - dsum;
        mag = div_sat(dmag * kinetic_q, spread_sq(), mgw_pkg::POS_FRAC, TERM_CAP);
        kin = neg ? -longint'(mag) : longint'(mag);
        ax = magnitude(x);
        x2q = (ax * ax) >> mgw_pkg::X2_SH;
        if (x2q >= (64'd1 << 32)) begin
            pot = longint'(TERM_CAP);
        end else begin
            x4q = (x2q * x2q) >> 16;
            pot = longint'(x4q) - longint'((64'd5 * x2q) >> 1);
            if (pot > longint'(TERM_CAP)) pot = longint'(TERM_CAP);
        end
        sum = kin + pot;
        if (sum > 64'sd8388607) sum = 64'sd8388607;
        if (sum < -64'sd8388608) sum = -64'sd8388608;
        return sum;
    endfunction

    function automatic t_walk_result walker_step(logic restart, u64 rm, u64 ra);
        t_walk_result res;
        u64 s, r, yo, bo, eo, yn, bn, en, c, lo, ln, p, ax;
        longint off, xn, fl, bin;
        res.moved = 1'b0;
        if (restart) begin
            walker_pos = start_pos_q;
        end else begin
            s = (peak_spread_q != 0) ? peak_spread_q : 64'd1;
            r = peak_offset_q + 64'd2 * s;
            off = longint'(((64'd2 * rm) * r) >> 24) - longint'(r);
            xn = walker_pos + off;
            if (xn > 64'sd8388607) xn = 64'sd8388607;
            if (xn < -64'sd8388608) xn = -64'sd8388608;
            gauss_shape(walker_pos, yo, bo, eo);
            gauss_shape(xn, yn, bn, en);
            c = (yo < yn) ? yo : yn;
            lo = (density_factor(eo) * exp_neg(yo - c)) >> 30;
            ln = (density_factor(en) * exp_neg(yn - c)) >> 30;
            if ((ln << 24) >= ra * lo) begin
                walker_pos = xn;
                res.moved = 1'b1;
            end
        end
        ax = magnitude(walker_pos);
        p = ax * bin_density_q;
        if (walker_pos >= 0) begin
            fl = longint'(p >> mgw_pkg::BIN_SH);
            bin = mgw_pkg::NUM_BINS / 2 + fl;
        end else begin
            fl = longint'((p + (64'd1 << mgw_pkg::BIN_SH) - 1) >> mgw_pkg::BIN_SH);
            bin = mgw_pkg::NUM_BINS / 2 - fl;
        end
        res.in_range = (bin >= 0) && (bin < mgw_pkg::NUM_BINS);
        if (bin < 0) bin = 0;
        if (bin >= mgw_pkg::NUM_BINS) bin = mgw_pkg::NUM_BINS - 1;
        res.pos = walker_pos[23:0];
        res.energy = 24'(energy_at(walker_pos));
        res.bin = 7'(bin);
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on beat %0d: %s got %0d, expected %0d", beats_seen, field, got, want);
        errors++;
    endtask

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_stall_stretch || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic reg_write(mgw_pkg::t_reg idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 5'(idx) << 2;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            mgw_pkg::REG_PEAK_OFFSET:    peak_offset_q = value[22:0];
            mgw_pkg::REG_PEAK_SPREAD:    peak_spread_q = value[22:0];
            mgw_pkg::REG_START_POSITION: start_pos_q = longint'(signed'(value[23:0]));
            mgw_pkg::REG_KINETIC_FACTOR: kinetic_q = value[22:0];
            mgw_pkg::REG_INV_BIN_WIDTH:  bin_density_q = value[23:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic load_setting(int phase);
        case (phase)
            1: begin
                reg_write(mgw_pkg::REG_PEAK_OFFSET, 32'h7FFFFF);
                reg_write(mgw_pkg::REG_PEAK_SPREAD, 32'h7FFFFF);
                reg_write(mgw_pkg::REG_START_POSITION, 32'h7FFFFF);
                reg_write(mgw_pkg::REG_KINETIC_FACTOR, 32'h7FFFFF);
                reg_write(mgw_pkg::REG_INV_BIN_WIDTH, 32'hFFFFFF);
            end
            2: begin
                reg_write(mgw_pkg::REG_PEAK_OFFSET, 32'h0);
                reg_write(mgw_pkg::REG_PEAK_SPREAD, 32'h0);
                reg_write(mgw_pkg::REG_START_POSITION, 32'h800000);
                reg_write(mgw_pkg::REG_KINETIC_FACTOR, 32'h0);
                reg_write(mgw_pkg::REG_INV_BIN_WIDTH, 32'h0);
                reg_write(mgw_pkg::t_reg'(3'd7), 32'hFFFFFFFF);
            end
            3: begin
                reg_write(mgw_pkg::REG_PEAK_OFFSET, 32'h100000);
                reg_write(mgw_pkg::REG_PEAK_SPREAD, 32'h10000);
                reg_write(mgw_pkg::REG_START_POSITION, 32'(-(3 << 20)));
                reg_write(mgw_pkg::REG_KINETIC_FACTOR, 32'h100000);
                reg_write(mgw_pkg::REG_INV_BIN_WIDTH, 32'h400000);
            end
            4: begin
                reg_write(mgw_pkg::REG_PEAK_OFFSET, $urandom_range(0, 32'h7FFFFF));
                reg_write(mgw_pkg::REG_PEAK_SPREAD, $urandom_range(1, 32'h7FFFFF));
                reg_write(mgw_pkg::REG_START_POSITION, $urandom);
                reg_write(mgw_pkg::REG_KINETIC_FACTOR, $urandom_range(0, 32'h7FFFFF));
                reg_write(mgw_pkg::REG_INV_BIN_WIDTH, $urandom_range(1, 32'hFFFFFF));
            end
            default: begin
                reg_write(mgw_pkg::REG_PEAK_OFFSET, 32'd838861);
                reg_write(mgw_pkg::REG_PEAK_SPREAD, 32'd200000);
                reg_write(mgw_pkg::REG_START_POSITION, 32'h100000);
                reg_write(mgw_pkg::REG_KINETIC_FACTOR, 32'd524288);
                reg_write(mgw_pkg::REG_INV_BIN_WIDTH, 32'd1310720);
            end
        endcase
    endtask

    task automatic send_beat(t_stim_row row, logic typed_check);
        t_walk_result res;
        int gap;
        i_action = row.restart;
        i_rand_move = row.rand_move;
        i_rand_accept = row.rand_accept;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = walker_step(row.restart, row.rand_move, row.rand_accept);
        if (typed_check && row.typed) begin
            res.pos = '0;
            res.moved = !row.restart;
            res.bin = 7'd64;
            res.in_range = 1'b1;
        end
        expected_beats.push_back(res);
        items_sent++;
        if (row.restart) restarts++;
        @(negedge i_clk);
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_beats.size() != 0) @(negedge i_clk);
    endtask

    t_stim_row directed [14] = '{
        '{1'b1, 24'h000000, 24'h000000, 1'b1},
        '{1'b0, 24'h800000, 24'hFFFFFF, 1'b1},
        '{1'b0, 24'h800000, 24'h000000, 1'b1},
        '{1'b0, 24'h000000, 24'h000000, 1'b0},
        '{1'b0, 24'hFFFFFF, 24'h000000, 1'b0},
        '{1'b0, 24'hFFFFFF, 24'h000000, 1'b0},
        '{1'b0, 24'hFFFFFF, 24'h000000, 1'b0},
        '{1'b0, 24'hFFFFFF, 24'h000000, 1'b0},
        '{1'b0, 24'hFFFFFF, 24'hFFFFFF, 1'b0},
        '{1'b0, 24'h000000, 24'hFFFFFF, 1'b0},
        '{1'b0, 24'h555555, 24'hAAAAAA, 1'b0},
        '{1'b0, 24'hAAAAAA, 24'h555555, 1'b0},
        '{1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b0},
        '{1'b0, 24'h000000, 24'h7FFFFF, 1'b0}
    };

    initial begin
        t_stim_row row;
        int pick;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = 1'b0;
        i_rand_move = '0;
        i_rand_accept = '0;
        i_out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_stall_stretch = 1'b0;
        peak_offset_q = 838861;
        peak_spread_q = 629146;
        start_pos_q = 0;
        kinetic_q = 524288;
        bin_density_q = 1310720;
        walker_pos = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int phase = 0; phase < N_PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                load_setting(phase);
            end
            foreach (directed[k]) send_beat(directed[k], phase == 0);
            no_stall_stretch = (phase == 3);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                row.restart = (pick < 5);
                row.rand_move = 24'($urandom);
                row.rand_accept = 24'($urandom);
                row.typed = 1'b0;
                if (pick >= 95) row.rand_accept = (pick[0]) ? 24'hFFFFFF : 24'h0;
                send_beat(row, 1'b0);
            end
            no_stall_stretch = 1'b0;
        end
        drain();
        repeat (700) @(posedge i_clk);
        $display("%0d items driven (%0d restarts) over %0d register settings,", items_sent,
                 restarts, N_PHASES);
        $display("%0d beats checked, %0d moves taken, %0d bins off the histogram.",
                 beats_seen, moves_taken, off_histogram);
        if (errors == 0) begin
            $display("metropolis_double_gaussian_walker test passed");
        end else begin
            $display("metropolis_double_gaussian_walker test failed");
        end
        $finish;
    end

    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            stall = gap_len();
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_walk_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                $display("beat %0d arrived with nothing expected", beats_seen);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                if (o_position !== want.pos)
                    report_mismatch("position", o_position, want.pos);
                if (o_move_accepted !== want.moved)
                    report_mismatch("move_accepted", o_move_accepted, want.moved);
                if (o_local_energy !== want.energy)
                    report_mismatch("local_energy", o_local_energy, want.energy);
                if (o_histogram_bin !== want.bin)
                    report_mismatch("histogram_bin", o_histogram_bin, want.bin);
                if (o_bin_in_range !== want.in_range)
                    report_mismatch("bin_in_range", o_bin_in_range, want.in_range);
                if (want.moved) moves_taken++;
                if (!want.in_range) off_histogram++;
            end
            beats_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("no beat moved for %0d cycles", WDOG_LIMIT);
            $display("metropolis_double_gaussian_walker test failed");
            $finish;
        end
    end

endmodule
